[design/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[design/rrtt_pkg.sv]
// Package for the round robin task table: payload structs, codes, defaults.
// No dependencies.
`default_nettype none

package rrtt_pkg;

    localparam int DEPTH_DEF     = 128;
    localparam int KEY_WIDTH_DEF = 16;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_NEXT    = 2'd1;
    localparam logic [1:0] CMD_DELETE  = 2'd2;
    localparam logic [1:0] CMD_REPLACE = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] task_key;
        logic [15:0] new_key;
    } t_in;

    typedef struct packed {
        logic [15:0] task_out;
        logic [1:0]  status;
        logic [7:0]  entry_count;
    } t_out;

    // Ring control from the sequencer to the cells.
    typedef struct packed {
        logic shift;
        logic wr_en;
    } t_ring_ctl;

endpackage

`default_nettype wire

[design/rrtt_cell.sv]
// One cell of the key ring: holds a key, takes its neighbor's key on shift, or loads
// the broadcast write data when writing is enabled and the write index names this cell.
// Depends on rrtt_pkg.
`default_nettype none

module rrtt_cell #(
    parameter int KEY_WIDTH = rrtt_pkg::KEY_WIDTH_DEF,
    parameter int AW        = 7,
    parameter int IDX       = 0
) (
    input  wire                     i_clk,
    input  rrtt_pkg::t_ring_ctl     i_ctl,
    input  wire [AW-1:0]            i_wr_idx,
    input  wire [KEY_WIDTH-1:0]     i_wr_data,
    input  wire [KEY_WIDTH-1:0]     i_shift_data,
    output logic [KEY_WIDTH-1:0]    o_key
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;

    always_comb begin
        n_key = r_key;
        if (i_ctl.wr_en && (i_wr_idx == AW'(IDX))) begin
            n_key = i_wr_data;
        end else if (i_ctl.shift) begin
            n_key = i_shift_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

`default_nettype wire

[design/rrtt_ctrl.sv]
// Sequencer of the task table: takes a transaction, rotates the key ring one
// full turn while it inspects the head cell, then commits and loads the result.
// Depends on rrtt_pkg.
`default_nettype none

module rrtt_ctrl #(
    parameter int DEPTH     = rrtt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = rrtt_pkg::KEY_WIDTH_DEF,
    parameter int AW        = $clog2(DEPTH),
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  rrtt_pkg::t_in           i_in_data,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output rrtt_pkg::t_out          o_out_data,
    input  wire [KEY_WIDTH-1:0]     i_head,
    output logic [KEY_WIDTH-1:0]    o_tail,
    output rrtt_pkg::t_ring_ctl     o_ctl,
    output logic [AW-1:0]           o_wr_idx,
    output logic [KEY_WIDTH-1:0]    o_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [1:0]           r_cmd, n_cmd;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [KEY_WIDTH-1:0] r_repl, n_repl;
    logic [AW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_ptr, n_ptr;
    logic [AW-1:0]        r_newptr, n_newptr;
    logic                 r_found, n_found;
    logic [AW-1:0]        r_hit, n_hit;
    logic [KEY_WIDTH-1:0] r_last, n_last;
    logic [KEY_WIDTH-1:0] r_served, n_served;
    logic                 r_out_valid, n_out_valid;
    rrtt_pkg::t_out       r_out, n_out;

    // Field width adaptation: keys pad/truncate to KEY_WIDTH, outputs to port widths.
    logic [KEY_WIDTH+15:0] key_pad, repl_pad, served_pad;
    logic [CW+7:0]         count_pad;
    logic [CW-1:0]         idx_ext;
    logic [CW-1:0]         ptr_inc;
    logic [CW-1:0]         count_dec;

    assign key_pad   = {{KEY_WIDTH{1'b0}}, i_in_data.task_key};
    assign repl_pad  = {{KEY_WIDTH{1'b0}}, i_in_data.new_key};
    assign idx_ext   = CW'(r_idx);
    assign ptr_inc   = CW'(r_ptr) + CW'(1);
    assign count_dec = r_count - CW'(1);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_repl      = r_repl;
        n_idx       = r_idx;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_newptr    = r_newptr;
        n_found     = r_found;
        n_hit       = r_hit;
        n_last      = r_last;
        n_served    = r_served;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_tail      = i_head;
        o_ctl       = '0;
        o_wr_idx    = r_hit;
        o_wr_data   = r_last;
        served_pad  = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in_data.cmd;
                    n_key    = key_pad[KEY_WIDTH-1:0];
                    n_repl   = repl_pad[KEY_WIDTH-1:0];
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_served = '0;
                    n_newptr = (ptr_inc == r_count) ? '0 : ptr_inc[AW-1:0];
                    n_state  = ST_RUN;
                end
            end
            ST_RUN: begin
                // head cell holds entry r_idx; o_tail becomes that entry after the turn
                o_ctl.shift = 1'b1;
                case (r_cmd) inside
                    rrtt_pkg::CMD_INSERT: begin
                        if ((r_count < CW'(DEPTH)) && (idx_ext == r_count)) begin
                            o_tail = r_key;
                        end
                    end
                    rrtt_pkg::CMD_NEXT: begin
                        if (r_idx == r_newptr) begin
                            n_served = i_head;
                        end
                    end
                    rrtt_pkg::CMD_DELETE, rrtt_pkg::CMD_REPLACE: begin
                        if (!r_found && (idx_ext < r_count) && (i_head == r_key)) begin
                            n_found = 1'b1;
                            n_hit   = r_idx;
                            if (r_cmd == rrtt_pkg::CMD_REPLACE) begin
                                o_tail = r_repl;
                            end
                        end
                        if (idx_ext == count_dec) begin
                            n_last = i_head;
                        end
                    end
                    default: ;
                endcase
                n_idx = r_idx + AW'(1);
                if (r_idx == AW'(DEPTH - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status = rrtt_pkg::STAT_OK;
                    case (r_cmd) inside
                        rrtt_pkg::CMD_INSERT: begin
                            if (r_count < CW'(DEPTH)) begin
                                n_count = r_count + CW'(1);
                            end else begin
                                n_out.status = rrtt_pkg::STAT_FULL;
                            end
                        end
                        rrtt_pkg::CMD_NEXT: begin
                            if (r_count == '0) begin
                                n_out.status = rrtt_pkg::STAT_EMPTY;
                            end else begin
                                n_ptr      = r_newptr;
                                served_pad = {16'd0, r_served};
                            end
                        end
                        rrtt_pkg::CMD_DELETE: begin
                            if (r_found) begin
                                o_ctl.wr_en = 1'b1;
                                n_count     = count_dec;
                                if (CW'(r_ptr) == count_dec) begin
                                    n_ptr = '0;
                                end
                            end else begin
                                n_out.status = rrtt_pkg::STAT_NOTFOUND;
                            end
                        end
                        rrtt_pkg::CMD_REPLACE: begin
                            if (!r_found) begin
                                n_out.status = rrtt_pkg::STAT_NOTFOUND;
                            end
                        end
                        default: ;
                    endcase
                    n_out.task_out = served_pad[15:0];
                    n_out.entry_count = count_pad[7:0];
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign count_pad = {8'd0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_repl   <= n_repl;
        r_idx    <= n_idx;
        r_newptr <= n_newptr;
        r_found  <= n_found;
        r_hit    <= n_hit;
        r_last   <= n_last;
        r_served <= n_served;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[design/round_robin_task_table_unit.sv]
// Top level of the round robin task table: sequencer plus a ring of key cells.
// Depends on rrtt_pkg, rrtt_cell, rrtt_ctrl.
//
//   channel | direction | handshake                  | payload
//   input   | in        | i_in_valid / o_in_ready    | i_in_data  (rrtt_pkg::t_in)
//   output  | out       | o_out_valid / i_out_ready  | o_out_data (rrtt_pkg::t_out)
//
// Every transaction is accepted in the idle state; then the key ring makes one full turn
// of DEPTH shifts, one per cycle, past the head cell, followed by the commit state.
// A new transaction is taken only after the previous one has committed.
// The sequencer takes a new transaction while the previous result waits in the
// output register; it holds in the commit cycle if that register is still full.
// Reset clears the entry count, serving pointer and handshake state; the key
// cells are not reset and hold nothing meaningful until written.
`default_nettype none

module round_robin_task_table_unit #(
    parameter int DEPTH     = rrtt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = rrtt_pkg::KEY_WIDTH_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  rrtt_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output rrtt_pkg::t_out  o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [KEY_WIDTH-1:0] keys [DEPTH];
    logic [KEY_WIDTH-1:0] tail;
    rrtt_pkg::t_ring_ctl  ring_ctl;
    logic [AW-1:0]        wr_idx;
    logic [KEY_WIDTH-1:0] wr_data;

    rrtt_ctrl #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_head      (keys[0]),
        .o_tail      (tail),
        .o_ctl       (ring_ctl),
        .o_wr_idx    (wr_idx),
        .o_wr_data   (wr_data)
    );

    // Ring: each cell takes its upper neighbor; the last cell takes the tail.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [KEY_WIDTH-1:0] shift_in;
        if (k == DEPTH - 1) begin : g_last
            assign shift_in = tail;
        end else begin : g_mid
            assign shift_in = keys[k+1];
        end
        rrtt_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .AW        (AW),
            .IDX       (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ring_ctl),
            .i_wr_idx     (wr_idx),
            .i_wr_data    (wr_data),
            .i_shift_data (shift_in),
            .o_key        (keys[k])
        );
    end

endmodule

`default_nettype wire

[design/rrtt_checker.sv]
// Port-level checker for the round robin task table, bound to the top level.
// Depends on rrtt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rrtt_checker #(
    parameter int DEPTH = rrtt_pkg::DEPTH_DEF
) (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_in_valid,
    input wire             o_in_ready,
    input rrtt_pkg::t_in   i_in_data,
    input wire             o_out_valid,
    input wire             i_out_ready,
    input rrtt_pkg::t_out  o_out_data
);

    localparam logic [7:0] DEPTH_LSB = 8'(DEPTH % 256);

    logic in_xact;
    logic out_fail;
    logic out_empty;
    logic out_full;

    assign in_xact   = i_in_valid && o_in_ready && (i_in_data.cmd == rrtt_pkg::CMD_NEXT);
    assign out_fail  = o_out_valid && (o_out_data.status != rrtt_pkg::STAT_OK);
    assign out_empty = o_out_valid && (o_out_data.status == rrtt_pkg::STAT_EMPTY);
    assign out_full  = o_out_valid && (o_out_data.status == rrtt_pkg::STAT_FULL);

    // A pending result is not dropped.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    // Only a successful next returns a key.
    `ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n, out_fail, o_out_data.task_out == 16'd0)
    // Empty is reported only with no entries.
    `ASSERT_IMPLY(a_empty_cnt, i_clk, i_rst_n, out_empty, o_out_data.entry_count == 8'd0)
    // A dropped insert means the table is at capacity.
    `ASSERT_IMPLY(a_full_cnt, i_clk, i_rst_n, out_full, o_out_data.entry_count == DEPTH_LSB)
    // An accepted next command occupies the ring for a full turn: no back-to-back acceptance.
    `ASSERT_NEXT(a_no_b2b, i_clk, i_rst_n, in_xact, !o_in_ready)

endmodule

bind round_robin_task_table_unit rrtt_checker #(
    .DEPTH (DEPTH)
) u_rrtt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

[test/round_robin_task_table_unit_tb.sv]
// Self-checking testbench for round_robin_task_table_unit: directed and random command
// streams against a cycle-free table model, with random idling on both channels.
// Depends on rrtt_pkg and the round_robin_task_table_unit RTL.
module round_robin_task_table_unit_tb;

    localparam int DEPTH        = rrtt_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS = 2000;
    localparam int TAIL_CYCLES  = 2 * (DEPTH + 2);
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int HOLDOFF_AT   = 100;
    localparam int HOLDOFF_LEN  = 1000;
    localparam int POOL_SIZE    = 24;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

    typedef struct {
        rrtt_pkg::t_in req;
        bit            drain;   // hold this transaction until every result is back
    } cmd_item_t;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    rrtt_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    rrtt_pkg::t_out o_out_data;

    round_robin_task_table_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Table model
    logic [15:0] tbl_keys [DEPTH];
    int          tbl_count;
    int          tbl_ptr;

    cmd_item_t      cmd_queue[$];
    rrtt_pkg::t_out table_result_q[$];
    logic [15:0]    key_pool [POOL_SIZE];

    int  err_count;
    int  in_count;
    int  out_count;
    int  cycle_count;
    bit  in_fire;
    int  holdoff_left;
    bit  holdoff_done;

    function automatic int find_key(logic [15:0] key);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_keys[i] == key) return i;
        end
        return tbl_count;
    endfunction

    function automatic rrtt_pkg::t_out predict_table_step(rrtt_pkg::t_in req);
        rrtt_pkg::t_out r;
        int             hit;
        r = '0;
        r.status = rrtt_pkg::STAT_OK;
        case (req.cmd)
            rrtt_pkg::CMD_INSERT: begin
                if (tbl_count < DEPTH) begin
                    tbl_keys[tbl_count] = req.task_key;
                    tbl_count++;
                end else begin
                    r.status = rrtt_pkg::STAT_FULL;
                end
            end
            rrtt_pkg::CMD_NEXT: begin
                if (tbl_count == 0) begin
                    r.status = rrtt_pkg::STAT_EMPTY;
                end else begin
                    tbl_ptr = (tbl_ptr + 1) % tbl_count;
                    r.task_out = tbl_keys[tbl_ptr];
                end
            end
            rrtt_pkg::CMD_DELETE: begin
                hit = find_key(req.task_key);
                if (hit < tbl_count) begin
                    // last entry fills the hole
                    tbl_keys[hit] = tbl_keys[tbl_count - 1];
                    tbl_count--;
                    if (tbl_ptr == tbl_count) tbl_ptr = 0;
                end else begin
                    r.status = rrtt_pkg::STAT_NOTFOUND;
                end
            end
            default: begin
                hit = find_key(req.task_key);
                if (hit < tbl_count) tbl_keys[hit] = req.new_key;
                else r.status = rrtt_pkg::STAT_NOTFOUND;
            end
        endcase
        r.entry_count = 8'(tbl_count);
        return r;
    endfunction

    task automatic add_cmd(logic [1:0] cmd, logic [15:0] key, logic [15:0] repl, bit drain);
        cmd_item_t item;
        item.req.cmd      = cmd;
        item.req.task_key = key;
        item.req.new_key  = repl;
        item.drain        = drain;
        cmd_queue.push_back(item);
    endtask

    // Mostly pool keys so deletes and replaces hit; some fully random keys.
    function automatic logic [15:0] pick_key();
        if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return 16'($urandom);
    endfunction

    task automatic add_random_chunk(mix_t mix, int n, bit drain);
        int         roll;
        int         ins_w;
        int         nxt_w;
        int         del_w;
        logic [1:0] cmd;
        case (mix)
            MIX_GROW:   begin ins_w = 80; nxt_w = 10; del_w = 5;  end
            MIX_SHRINK: begin ins_w = 10; nxt_w = 20; del_w = 60; end
            default:    begin ins_w = 30; nxt_w = 30; del_w = 20; end
        endcase
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_w) cmd = rrtt_pkg::CMD_INSERT;
            else if (roll < ins_w + nxt_w) cmd = rrtt_pkg::CMD_NEXT;
            else if (roll < ins_w + nxt_w + del_w) cmd = rrtt_pkg::CMD_DELETE;
            else cmd = rrtt_pkg::CMD_REPLACE;
            add_cmd(cmd, pick_key(), pick_key(), drain && (i == 0));
        end
    endtask

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("round_robin_task_table_unit_tb: errors");
            $finish;
        end
    end

    // Monitor: result check first, then record the accepted command.
    always @(posedge i_clk) begin
        rrtt_pkg::t_out want;
        in_fire = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                out_count++;
                if (table_result_q.size() == 0) begin
                    $error("result with nothing expected: %h", o_out_data);
                    err_count++;
                end else begin
                    want = table_result_q.pop_front();
                    if (o_out_data.task_out !== want.task_out) begin
                        $error("task_out: expected %h, actual %h",
                               want.task_out, o_out_data.task_out);
                        err_count++;
                    end
                    if (o_out_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, o_out_data.status);
                        err_count++;
                    end
                    if (o_out_data.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, o_out_data.entry_count);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                in_fire = 1'b1;
                in_count++;
                table_result_q.push_back(predict_table_step(i_in_data));
            end
        end
    end

    function automatic int sender_idle_pct();
        if (in_count < 700) return 11;
        if (in_count < 1400) return 62;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (in_count < 700) return 62;
        if (in_count < 1400) return 11;
        return 0;
    endfunction

    // Driver: a presented transaction is held until the monitor saw it accepted.
    always @(negedge i_clk) begin
        bit            next_valid;
        rrtt_pkg::t_in next_data;
        cmd_item_t     next_item;
        next_valid = 1'b0;
        next_data  = i_in_data;
        if (i_rst_n) begin
            if (i_in_valid && !in_fire) begin
                next_valid = 1'b1;
            end else if (cmd_queue.size() != 0
                         && !(cmd_queue[0].drain && table_result_q.size() != 0)
                         && $urandom_range(0, 99) >= sender_idle_pct()) begin
                next_valid = 1'b1;
                next_item  = cmd_queue.pop_front();
                next_data  = next_item.req;
            end
            i_in_valid <= next_valid;
            i_in_data  <= next_data;
        end
    end

    // Receiver, with one long hold-off to back the block up.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!holdoff_done && out_count >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
            end
        end
    end

    initial begin
        int   total;
        mix_t mix;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_ready  = 1'b0;
        err_count    = 0;
        in_count     = 0;
        out_count    = 0;
        cycle_count  = 0;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        tbl_count    = 0;
        tbl_ptr      = 0;
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom);

        // Directed: empty table, key extremes, wrap, duplicates, pointer reset.
        add_cmd(rrtt_pkg::CMD_NEXT,    16'h0000, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_DELETE,  16'h0000, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_REPLACE, 16'hFFFF, 16'hFFFF, 1'b0);
        add_cmd(rrtt_pkg::CMD_INSERT,  16'h0000, 16'hFFFF, 1'b0);
        add_cmd(rrtt_pkg::CMD_NEXT,    16'h0000, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_INSERT,  16'hFFFF, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_INSERT,  16'h1234, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_INSERT,  16'h1234, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_NEXT,    16'h0000, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_NEXT,    16'h0000, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_NEXT,    16'h0000, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_NEXT,    16'h0000, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_REPLACE, 16'h1234, 16'hABCD, 1'b0);
        add_cmd(rrtt_pkg::CMD_NEXT,    16'h0000, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_NEXT,    16'h0000, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_NEXT,    16'h0000, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_DELETE,  16'h1234, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_DELETE,  16'h5555, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_REPLACE, 16'h5555, 16'h0001, 1'b0);
        add_cmd(rrtt_pkg::CMD_DELETE,  16'h0000, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_NEXT,    16'h0000, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_DELETE,  16'hABCD, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_DELETE,  16'hFFFF, 16'h0000, 1'b0);
        add_cmd(rrtt_pkg::CMD_NEXT,    16'h0000, 16'h0000, 1'b0);

        // Random: open with a long fill run so the full-table case is reached.
        add_random_chunk(MIX_GROW, 200, 1'b1);
        total = 200;
        while (total < RANDOM_ITEMS) begin
            int n;
            n   = $urandom_range(50, 250);
            mix = mix_t'($urandom_range(0, 2));
            add_random_chunk(mix, n, $urandom_range(0, 3) == 0);
            total += n;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || i_in_valid || table_result_q.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (err_count == 0 && table_result_q.size() == 0) begin
            $display("round_robin_task_table_unit_tb: clean");
        end else begin
            $display("round_robin_task_table_unit_tb: errors");
        end
        $finish;
    end
endmodule
